[sv/bba_pkg.sv]
`timescale 1ns / 1ps

package bba_pkg;

    // Request codes carried in req_type.
    localparam logic [2:0] REQ_ALLOC   = 3'd0;
    localparam logic [2:0] REQ_CLAIM   = 3'd1;
    localparam logic [2:0] REQ_RELEASE = 3'd2;
    localparam logic [2:0] REQ_WRITE   = 3'd3;
    localparam logic [2:0] REQ_READ    = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_BADID = 2'd2;
    localparam logic [1:0] ST_USED  = 2'd3;

    // The bitmap is kept as words of this many bits.
    localparam int MAP_WORD_W   = 32;
    localparam int MAP_BIT_IDXW = 5;

    typedef struct packed {
        logic [2:0] req_type;
        logic [9:0] target_blk;
        logic [7:0] byte_offset;
        logic [7:0] write_byte;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] granted_id;
        logic [7:0] read_byte;
        logic [8:0] used_count;
        logic [8:0] free_count;
    } t_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic check;
        logic access;
        logic modify;
    } t_cmd;

    // Status from the datapath to the controller, valid in the check step.
    typedef struct packed {
        logic stop;
        logic skip_modify;
    } t_sts;

endpackage

[sv/bba_ram.sv]
`timescale 1ns / 1ps

module bba_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/bba_ctrl.sv]
`timescale 1ns / 1ps

module bba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  bba_pkg::t_sts i_sts,
    output logic          busy,
    output logic          o_done,
    output bba_pkg::t_cmd o_cmd
);
    import bba_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_ACCESS = 3'd2;
    localparam logic [2:0] S_MODIFY = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    // A new request may be taken while the previous result is on the ports.
    assign busy   = (r_state != S_IDLE) && (r_state != S_RESP);
    assign accept = start && !busy;
    assign o_done = (r_state == S_RESP);

    always_comb begin
        o_cmd.load   = accept;
        o_cmd.check  = (r_state == S_CHECK);
        o_cmd.access = (r_state == S_ACCESS);
        o_cmd.modify = (r_state == S_MODIFY);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE, S_RESP: begin
                n_state = accept ? S_CHECK : S_IDLE;
            end
            S_CHECK: begin
                n_state = i_sts.stop ? S_RESP : S_ACCESS;
            end
            S_ACCESS: begin
                n_state = i_sts.skip_modify ? S_RESP : S_MODIFY;
            end
            S_MODIFY: begin
                n_state = S_RESP;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[sv/bba_dp.sv]
`timescale 1ns / 1ps

module bba_dp #(
    parameter int NUM_BLOCKS  = 256,
    parameter int BLOCK_BYTES = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bba_pkg::t_req i_req,
    input  bba_pkg::t_cmd i_cmd,
    output bba_pkg::t_sts o_sts,
    output bba_pkg::t_rsp o_rsp
);
    import bba_pkg::*;

    localparam int NW     = (NUM_BLOCKS + MAP_WORD_W - 1) / MAP_WORD_W;
    localparam int WIW    = (NW > 1) ? $clog2(NW) : 1;
    localparam int CW     = $clog2(NUM_BLOCKS + 1);
    localparam int BDEPTH = NUM_BLOCKS * BLOCK_BYTES;
    localparam int AW     = $clog2(BDEPTH);

    t_req                  r_req;
    logic [WIW-1:0]        r_widx;
    logic [AW-1:0]         r_baddr;
    logic [1:0]            r_status;
    logic [7:0]            r_grant;
    logic [7:0]            r_rbyte;
    logic [CW-1:0]         r_used;
    logic [NW-1:0]         r_wvalid;
    logic [NW-1:0]         r_full;

    logic                  id_ok;
    logic                  off_ok;
    logic                  any_free;
    logic [WIW-1:0]        free_widx;
    logic [1:0]            chk_status;
    logic [AW-1:0]         baddr;

    logic [MAP_WORD_W-1:0] map_rdata;
    logic [MAP_WORD_W-1:0] pad_mask;
    logic [MAP_WORD_W-1:0] eff_word;
    logic [MAP_WORD_W-1:0] new_word;
    logic [MAP_BIT_IDXW-1:0] low_zero;
    logic [MAP_BIT_IDXW-1:0] tgt_bit;
    logic                  map_op;
    logic                  map_we;
    logic                  inc_used;
    logic                  dec_used;
    logic                  was_used;
    logic [7:0]            byte_rdata;
    logic                  byte_we;

    assign id_ok  = (32'(r_req.target_blk) < NUM_BLOCKS);
    assign off_ok = (32'(r_req.byte_offset) < BLOCK_BYTES);
    assign baddr  = AW'(r_req.target_blk) * AW'(BLOCK_BYTES) + AW'(r_req.byte_offset);

    // Lowest word of the bitmap that still has a free block.
    always_comb begin
        any_free  = 1'b0;
        free_widx = '0;
        for (int w = NW - 1; w >= 0; w--) begin
            if (!r_full[w]) begin
                any_free  = 1'b1;
                free_widx = WIW'(w);
            end
        end
    end

    always_comb begin
        o_sts.stop        = 1'b0;
        o_sts.skip_modify = (r_req.req_type == REQ_WRITE);
        chk_status        = ST_OK;
        unique case (r_req.req_type)
            REQ_ALLOC: begin
                o_sts.stop = !any_free;
                chk_status = any_free ? ST_OK : ST_FULL;
            end
            REQ_CLAIM, REQ_RELEASE: begin
                o_sts.stop = !id_ok;
                chk_status = id_ok ? ST_OK : ST_BADID;
            end
            REQ_WRITE, REQ_READ: begin
                o_sts.stop = !(id_ok && off_ok);
                chk_status = (id_ok && off_ok) ? ST_OK : ST_BADID;
            end
            default: begin
                o_sts.stop = 1'b1;
            end
        endcase
    end

    // Bits past the last block count as used so they are never granted.
    always_comb begin
        for (int b = 0; b < MAP_WORD_W; b++) begin
            pad_mask[b] = (32'({r_widx, MAP_BIT_IDXW'(b)}) >= NUM_BLOCKS);
        end
    end

    assign eff_word = (r_wvalid[r_widx] ? map_rdata : '0) | pad_mask;

    always_comb begin
        low_zero = '0;
        for (int b = MAP_WORD_W - 1; b >= 0; b--) begin
            if (!eff_word[b]) begin
                low_zero = MAP_BIT_IDXW'(b);
            end
        end
    end

    assign map_op  = (r_req.req_type == REQ_ALLOC) || (r_req.req_type == REQ_CLAIM)
                  || (r_req.req_type == REQ_RELEASE);
    assign tgt_bit = (r_req.req_type == REQ_ALLOC) ? low_zero
                                                   : r_req.target_blk[MAP_BIT_IDXW-1:0];
    assign was_used = eff_word[tgt_bit];

    always_comb begin
        new_word = eff_word;
        inc_used = 1'b0;
        dec_used = 1'b0;
        if (r_req.req_type == REQ_RELEASE) begin
            new_word[tgt_bit] = 1'b0;
            dec_used          = was_used;
        end else begin
            new_word[tgt_bit] = 1'b1;
            inc_used          = !was_used;
        end
    end

    assign map_we  = i_cmd.modify && map_op;
    assign byte_we = i_cmd.access && (r_req.req_type == REQ_WRITE);

    bba_ram #(
        .WIDTH  (MAP_WORD_W),
        .DEPTH  (NW),
        .ADDR_W (WIW)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_addr  (r_widx),
        .i_wdata (new_word),
        .o_rdata (map_rdata)
    );

    bba_ram #(
        .WIDTH  (8),
        .DEPTH  (BDEPTH),
        .ADDR_W (AW)
    ) u_byte_ram (
        .i_clk   (i_clk),
        .i_we    (byte_we),
        .i_addr  (r_baddr),
        .i_wdata (r_req.write_byte),
        .o_rdata (byte_rdata)
    );

    // Request, address and result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req    <= i_req;
            r_status <= ST_OK;
            r_grant  <= '0;
            r_rbyte  <= '0;
        end
        if (i_cmd.check) begin
            r_status <= chk_status;
            r_widx   <= (r_req.req_type == REQ_ALLOC) ? free_widx
                                                      : r_req.target_blk[MAP_BIT_IDXW +: WIW];
            r_baddr  <= baddr;
        end
        if (i_cmd.modify) begin
            if (r_req.req_type == REQ_READ) begin
                r_rbyte <= byte_rdata;
            end
            if (r_req.req_type == REQ_ALLOC) begin
                r_grant <= 8'({r_widx, low_zero});
            end
            if ((r_req.req_type == REQ_CLAIM) && was_used) begin
                r_status <= ST_USED;
            end
        end
    end

    // Bitmap bookkeeping that reset must clear.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_wvalid <= '0;
            r_full   <= '0;
        end else if (map_we) begin
            r_wvalid[r_widx] <= 1'b1;
            r_full[r_widx]   <= &new_word;
            if (inc_used) begin
                r_used <= r_used + CW'(1);
            end else if (dec_used) begin
                r_used <= r_used - CW'(1);
            end
        end
    end

    always_comb begin
        o_rsp.status     = r_status;
        o_rsp.granted_id = r_grant;
        o_rsp.read_byte  = r_rbyte;
        o_rsp.used_count = 9'(r_used);
        o_rsp.free_count = 9'(CW'(NUM_BLOCKS) - r_used);
    end

endmodule

[sv/bitmap_block_allocator_top.sv]
// Allocate, claim, release and read requests pass through check, memory access, modify and result;
// a byte write skips modify, and a request refused at the check step goes straight to its result.
// No new request is taken while one is in progress; start is taken again in the result cycle.
// The steps are set by the read-modify-write of one bitmap word in a RAM with registered read.
// Reset is synchronous and active low; it marks every block free and leaves the byte store as is.
// The receiver cannot stall: each result is shown for exactly one cycle with o_done.
`timescale 1ns / 1ps

module bitmap_block_allocator_top #(
    parameter int NUM_BLOCKS  = 256,
    parameter int BLOCK_BYTES = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  bba_pkg::t_req i_req,
    output logic          busy,
    output logic          o_done,
    output bba_pkg::t_rsp o_rsp
);
    import bba_pkg::*;

    // The controller steps each request through check, memory access, modify and respond; a write
    // skips modify and a refused one goes from check to respond. The datapath holds the request,
    // the bitmap RAM with per-word valid and full flags, the used counter and the byte store RAM.
    t_cmd cmd;
    t_sts sts;

    bba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    // The allocate search works in two steps: the full flags pick the lowest word
    // that still has room, and after that word is read its lowest free bit is taken.
    bba_dp #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_rsp)
    );

endmodule

[sv/bba_checker.sv]
`timescale 1ns / 1ps

module bba_checker #(
    parameter int NUM_BLOCKS = 256
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_done,
    input bba_pkg::t_rsp o_rsp
);
    import bba_pkg::*;

    // Every request passes through the check step before its result, so no two results are adjacent.
    a_done_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("results in back-to-back cycles");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not make the block busy");

    a_done_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("busy while a result is shown");

    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (9'(o_rsp.used_count + o_rsp.free_count) == 9'(NUM_BLOCKS)))
        else $error("used and free counts do not add up");

    a_full_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status == ST_FULL)) |->
            ((o_rsp.granted_id == 8'd0) && (o_rsp.read_byte == 8'd0)))
        else $error("full status with nonzero payload");

endmodule

bind bitmap_block_allocator_top bba_checker #(
    .NUM_BLOCKS (NUM_BLOCKS)
) u_bba_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_rsp   (o_rsp)
);

[tb/tb_bitmap_block_allocator_top.sv]
`timescale 1ns / 1ps

module tb_bitmap_block_allocator_top;
    import bba_pkg::*;

    // The block is built at its default size. With 256-byte blocks every 8-bit
    // offset is in range, so only the block id can make an access out of range.
    localparam int N_BLK  = 256;
    localparam int BLK_SZ = 256;

    // Request codes above the defined set. The block must treat them as no-ops.
    localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

    // The run is abandoned after this many cycles in a row with no request taken.
    localparam int STALL_LIMIT = 2000;
    // This many extra cycles after the last result catch any stray strobe.
    localparam int TAIL_CYCLES = 8;
    localparam int RAND_REQS   = 1600;

    typedef enum {K_ALLOC, K_CLAIM, K_RELEASE, K_WRITE, K_READ, K_SPARE} t_kind;
    typedef enum {M_FILL, M_DRAIN, M_MIXED} t_mode;

    // The scoreboard keeps its own copy of the bitmap, the used count and every
    // byte written so far. It works out each response when the request is taken
    // and queues it. Responses come back strictly in order, one per request.
    class alloc_scoreboard;
        bit          used[N_BLK];
        int unsigned used_total;
        logic [7:0]  store[int];
        int          written[$];
        t_rsp        awaited[$];
        int          errors;
        int          n_req, n_full, n_taken, n_badid, n_reads;

        function void note(t_req r);
            t_rsp e;
            bit   id_ok;
            bit   off_ok;
            bit   found;
            int   addr;
            e      = '0;
            e.status = ST_OK;
            id_ok  = r.target_blk < N_BLK;
            off_ok = r.byte_offset < BLK_SZ;
            addr   = int'(r.target_blk) * BLK_SZ + int'(r.byte_offset);
            case (r.req_type)
                REQ_ALLOC: begin
                    found = 1'b0;
                    for (int i = 0; i < N_BLK; i++) begin
                        if (!found && !used[i]) begin
                            used[i]      = 1'b1;
                            used_total++;
                            e.granted_id = 8'(i);
                            found        = 1'b1;
                        end
                    end
                    if (!found) e.status = ST_FULL;
                end
                REQ_CLAIM: begin
                    if (!id_ok) begin
                        e.status = ST_BADID;
                    end else if (used[r.target_blk]) begin
                        e.status = ST_USED;
                    end else begin
                        used[r.target_blk] = 1'b1;
                        used_total++;
                    end
                end
                REQ_RELEASE: begin
                    if (!id_ok) begin
                        e.status = ST_BADID;
                    end else if (used[r.target_blk]) begin
                        used[r.target_blk] = 1'b0;
                        used_total--;
                    end
                end
                REQ_WRITE: begin
                    if (!id_ok || !off_ok) begin
                        e.status = ST_BADID;
                    end else begin
                        if (!store.exists(addr)) written.push_back(addr);
                        store[addr] = r.write_byte;
                    end
                end
                REQ_READ: begin
                    if (!id_ok || !off_ok) begin
                        e.status = ST_BADID;
                    end else begin
                        e.read_byte = store.exists(addr) ? store[addr] : 8'h00;
                        n_reads++;
                    end
                end
                default: ;
            endcase
            e.used_count = used_total[8:0];
            e.free_count = 9'(N_BLK - used_total);
            case (e.status)
                ST_FULL:  n_full++;
                ST_USED:  n_taken++;
                ST_BADID: n_badid++;
                default: ;
            endcase
            n_req++;
            awaited.push_back(e);
        endfunction

        function void cmp(string field, logic [8:0] want, logic [8:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check(t_rsp got);
            t_rsp e;
            if (awaited.size() == 0) begin
                $error("response with no request outstanding: %p", got);
                errors++;
                return;
            end
            e = awaited.pop_front();
            cmp("status", 9'(e.status), 9'(got.status));
            cmp("granted_id", 9'(e.granted_id), 9'(got.granted_id));
            cmp("read_byte", 9'(e.read_byte), 9'(got.read_byte));
            cmp("used_count", e.used_count, got.used_count);
            cmp("free_count", e.free_count, got.free_count);
        endfunction

        // Returns some block that is marked used, or -1 when the map is empty.
        function int pick_used();
            int s;
            s = $urandom_range(N_BLK - 1);
            for (int k = 0; k < N_BLK; k++) begin
                if (used[(s + k) % N_BLK]) return (s + k) % N_BLK;
            end
            return -1;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    t_req i_req;
    logic busy;
    logic o_done;
    t_rsp o_rsp;

    alloc_scoreboard book;
    int              idle_run;

    bitmap_block_allocator_top #(
        .NUM_BLOCKS (N_BLK),
        .BLOCK_BYTES(BLK_SZ)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (i_req),
        .busy   (busy),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    always #6 i_clk = ~i_clk;

    // Every response is shown for exactly one cycle with o_done. It is taken at
    // the rising edge that closes that cycle and checked straight away.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) book.check(o_rsp);
    end

    // The watchdog counts cycles in a row in which no request is taken. A block
    // that hangs, whether it stays busy or never answers the last request,
    // runs into this limit.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && start === 1'b1 && busy === 1'b0) begin
            idle_run <= 0;
        end else if (idle_run >= STALL_LIMIT) begin
            $display("Timed out after %0d cycles with no request taken.", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    function automatic t_req mk(logic [2:0] q, int id, int off, int d);
        t_req r;
        r.req_type    = q;
        r.target_blk  = 10'(id);
        r.byte_offset = 8'(off);
        r.write_byte  = 8'(d);
        return r;
    endfunction

    // Any valid block id, or an id at or above the block count.
    function automatic logic [9:0] some_id(int bad_pct);
        if ($urandom_range(99) < bad_pct) return 10'($urandom_range(1023, N_BLK));
        return 10'($urandom_range(N_BLK - 1));
    endfunction

    // The mode sets how the request kinds are mixed. Filling leans on allocate
    // so the map runs full and the no-free-block answer turns up. Draining
    // leans on release so the map empties out again.
    function automatic t_kind pick_kind(t_mode m);
        int w[6];
        int r;
        int acc;
        case (m)
            M_FILL:  w = '{60, 12, 4, 10, 10, 4};
            M_DRAIN: w = '{5, 5, 60, 13, 13, 4};
            default: w = '{20, 15, 20, 20, 20, 5};
        endcase
        r   = $urandom_range(99);
        acc = 0;
        for (int k = 0; k < 6; k++) begin
            acc += w[k];
            if (r < acc) return t_kind'(k);
        end
        return K_SPARE;
    endfunction

    // Fields that a request does not use are left random, so their bits still
    // toggle. A read only goes to a byte that has already been written, or else
    // to an out-of-range id, so the store is never read before it holds data.
    function automatic t_req make_req(t_mode m);
        t_req r;
        int   u;
        int   addr;
        r.target_blk  = 10'($urandom_range(1023));
        r.byte_offset = 8'($urandom_range(255));
        r.write_byte  = 8'($urandom_range(255));
        case (pick_kind(m))
            K_ALLOC: r.req_type = REQ_ALLOC;
            K_CLAIM: begin
                r.req_type   = REQ_CLAIM;
                r.target_blk = some_id(15);
            end
            K_RELEASE: begin
                r.req_type = REQ_RELEASE;
                u = book.pick_used();
                if (u >= 0 && $urandom_range(99) < 70) r.target_blk = 10'(u);
                else r.target_blk = some_id(20);
            end
            K_WRITE: begin
                r.req_type   = REQ_WRITE;
                r.target_blk = some_id(15);
            end
            K_READ: begin
                r.req_type = REQ_READ;
                if (book.written.size() > 0 && $urandom_range(99) < 85) begin
                    addr          = book.written[$urandom_range(book.written.size() - 1)];
                    r.target_blk  = 10'(addr / BLK_SZ);
                    r.byte_offset = 8'(addr % BLK_SZ);
                end else begin
                    r.target_blk = 10'($urandom_range(1023, N_BLK));
                end
            end
            default: r.req_type = 3'($urandom_range(REQ_SPARE_LAST, REQ_SPARE_FIRST));
        endcase
        return r;
    endfunction

    // Start is lowered for the gap, then raised with the request at a falling
    // edge and held until a rising edge finds busy low. The next request goes
    // out at the following falling edge. If there is no gap, start simply stays
    // high, so it gets only one assignment in that time step.
    task automatic issue(input t_req r, input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        forever begin
            @(posedge i_clk);
            if (busy === 1'b0) break;
        end
        book.note(r);
    endtask

    initial begin
        t_req  dir[$];
        t_mode mode;
        int    pct;
        int    gap;

        book     = new();
        idle_run = 0;
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_req    = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The directed requests come first. Two allocations on an empty map get
        // blocks 0 and 1. Claims go to the top valid id, to the same id a second
        // time, and to the first bad id and the largest bad id. Release goes to
        // a free block, to a used one and to a bad id. Writes and reads hit the
        // corners of the store, and two writes go to blocks that are still
        // free. Accesses with bad ids and every spare request code follow.
        // A claim of an allocated block, and its release and reallocation, end
        // the list. The map runs full later, in the fill phases.
        dir.push_back(mk(REQ_ALLOC,   0, 0, 0));
        dir.push_back(mk(REQ_ALLOC,   1023, 255, 255));
        dir.push_back(mk(REQ_CLAIM,   N_BLK - 1, 0, 0));
        dir.push_back(mk(REQ_CLAIM,   N_BLK - 1, 255, 255));
        dir.push_back(mk(REQ_CLAIM,   N_BLK, 0, 0));
        dir.push_back(mk(REQ_CLAIM,   1023, 0, 0));
        dir.push_back(mk(REQ_RELEASE, 200, 0, 0));
        dir.push_back(mk(REQ_RELEASE, N_BLK - 1, 0, 0));
        dir.push_back(mk(REQ_RELEASE, 1023, 0, 0));
        dir.push_back(mk(REQ_WRITE,   0, 0, 8'h00));
        dir.push_back(mk(REQ_WRITE,   N_BLK - 1, BLK_SZ - 1, 8'hFF));
        dir.push_back(mk(REQ_WRITE,   100, 128, 8'hA5));
        dir.push_back(mk(REQ_READ,    0, 0, 8'hFF));
        dir.push_back(mk(REQ_READ,    N_BLK - 1, BLK_SZ - 1, 0));
        dir.push_back(mk(REQ_READ,    100, 128, 0));
        dir.push_back(mk(REQ_WRITE,   512, 7, 8'h5A));
        dir.push_back(mk(REQ_READ,    1023, 255, 0));
        for (int q = REQ_SPARE_FIRST; q <= REQ_SPARE_LAST; q++) begin
            dir.push_back(mk(3'(q), 1023, 255, 255));
        end
        dir.push_back(mk(REQ_CLAIM,   0, 0, 0));
        dir.push_back(mk(REQ_RELEASE, 0, 0, 0));
        dir.push_back(mk(REQ_ALLOC,   0, 0, 0));
        foreach (dir[k]) issue(dir[k], 0);

        // The random part runs in blocks of 400 requests: fill, drain, fill,
        // then a mixed load. The sender's idle rate changes every 200 requests
        // and goes through none, 51 percent, none and 34 percent. The third
        // step would stall the receiver, but this interface gives the receiver
        // no way to hold a response back, so the sender runs without gaps then.
        for (int n = 0; n < RAND_REQS; n++) begin
            case ((n / 400) % 4)
                0, 2:    mode = M_FILL;
                1:       mode = M_DRAIN;
                default: mode = M_MIXED;
            endcase
            case ((n / 200) % 4)
                1:       pct = 51;
                3:       pct = 34;
                default: pct = 0;
            endcase
            gap = ($urandom_range(99) < pct) ? $urandom_range(5, 1) : 0;
            issue(make_req(mode), gap);
        end

        @(negedge i_clk);
        start <= 1'b0;

        // Wait for the last response. The watchdog catches a block that never
        // sends it. A few more cycles then show up any extra strobe.
        while (book.awaited.size() > 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests: %0d allocs on a full map, %0d claims of used blocks.",
                 book.n_req, book.n_full, book.n_taken);
        $display("%0d requests had a bad id and %0d stored bytes were read back.",
                 book.n_badid, book.n_reads);
        if (book.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[bitmap_block_allocator_top.f]
sv/bba_pkg.sv
sv/bba_ram.sv
sv/bba_ctrl.sv
sv/bba_dp.sv
sv/bitmap_block_allocator_top.sv
sv/bba_checker.sv
tb/tb_bitmap_block_allocator_top.sv
